/* rtl/prlc_pkg.sv */
`timescale 1ns / 1ps

package prlc_pkg;

  // Field widths
  localparam int unsigned ColW    = 10;
  localparam int unsigned RowW    = 10;
  localparam int unsigned PixW    = 8;
  localparam int unsigned FracW   = 8;
  localparam int unsigned TrigW   = 18;
  localparam int unsigned CoordW  = 24;
  localparam int unsigned LensCW  = 20;
  localparam int unsigned KappaW  = 16;
  localparam int unsigned ApbDW   = 32;
  localparam int unsigned ApbAW   = 5;

  // Frame limits
  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;

  // Register reset values
  localparam logic signed [TrigW-1:0]  CosReset   = 18'sd65536;
  localparam logic signed [TrigW-1:0]  SinReset   = 18'sd0;
  localparam logic signed [CoordW-1:0] RotCxReset = 24'sd0;
  localparam logic signed [CoordW-1:0] RotCyReset = 24'sd0;
  localparam logic                     LensEnReset = 1'b0;
  localparam logic [LensCW-1:0]        LensCxReset = 20'd98048;
  localparam logic [LensCW-1:0]        LensCyReset = 20'd65792;
  localparam logic [KappaW-1:0]        KappaReset  = 16'd36284;

  typedef enum logic [2:0] {
    REG_COS     = 3'd0,
    REG_SIN     = 3'd1,
    REG_ROT_CX  = 3'd2,
    REG_ROT_CY  = 3'd3,
    REG_LENS_EN = 3'd4,
    REG_LENS_CX = 3'd5,
    REG_LENS_CY = 3'd6,
    REG_KAPPA   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [TrigW-1:0]  cos_half_angle;
    logic signed [TrigW-1:0]  sin_half_angle;
    logic signed [CoordW-1:0] rot_center_x;
    logic signed [CoordW-1:0] rot_center_y;
    logic                     lens_enable;
    logic [LensCW-1:0]        lens_center_x;
    logic [LensCW-1:0]        lens_center_y;
    logic [KappaW-1:0]        kappa;
  } cfg_t;

endpackage

/* rtl/pixel_rotate_lens_correct_unit.sv */
`timescale 1ns / 1ps

// Per-pixel radial lens correction followed by a half-angle rotation.
// Input channel (in_valid_i/in_ready_o) carries column, row and intensity;
// output channel (out_valid_o/out_ready_i) carries the Q.8 coordinate pair,
// saturated to 24 bits, and the intensity unchanged. One result per transfer.
// Registers sit on an APB port (pready always high); write them only while
// no pixel is in flight.
// Throughput: one pixel per cycle while out_ready_i is high, through the
// 12-stage pipeline; the wide kappa and correction multipliers are split
// into narrow partial products with a register after each.
// A stalled receiver holds the output register; each stage keeps taking
// transfers while a stage ahead of it is empty, so bubbles are squeezed out
// and in_ready_o drops only once all 12 stages hold a pixel.
// Reset empties the pipeline and loads the register defaults: no lens
// correction, identity rotation about the origin.
// Columns or rows at or beyond the frame limits are clamped to the last one.

module pixel_rotate_lens_correct_unit import prlc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ColW-1:0]          col_i,
  input  logic [RowW-1:0]          row_i,
  input  logic [PixW-1:0]          pixel_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CoordW-1:0] x_out_o,
  output logic signed [CoordW-1:0] y_out_o,
  output logic [PixW-1:0]          value_out_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ApbAW-1:0]         paddr,
  input  logic [ApbDW-1:0]         pwdata,
  output logic [ApbDW-1:0]         prdata,
  output logic                     pready
);

  localparam int unsigned NS = 12;
  localparam logic [ColW-1:0] ColLim = ColW'(MAX_WIDTH - 1);
  localparam logic [RowW-1:0] RowLim = RowW'(MAX_HEIGHT - 1);
  localparam logic signed [55:0] LensHalf = 56'sd1 <<< 31;
  localparam logic signed [45:0] RotHalf  = 46'sd1 <<< 15;
  localparam logic [57:0]        CorrHalf = 58'd1 << 23;

  cfg_t cfg;

  prlc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign pready = 1'b1;

  // Pipeline control
  logic [NS:1]   v_q;
  logic [NS:1]   v_prev;
  logic [NS+1:1] stage_en;

  assign v_prev = {v_q[NS-1:1], in_valid_i};

  always_comb begin
    stage_en[NS+1] = out_ready_i;
    for (int k = NS; k >= 1; k--) begin
      stage_en[k] = !v_q[k] || stage_en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (stage_en[k]) begin
          v_q[k] <= v_prev[k];
        end
      end
    end
  end

  assign in_ready_o  = stage_en[1];
  assign out_valid_o = v_q[NS];

  // Stage 1: clamp, scale to Q.8, offset from lens centre
  logic [ColW-1:0]    col_c;
  logic [RowW-1:0]    row_c;
  logic [17:0]        s1_xl_d, s1_yl_d;
  logic signed [20:0] s1_xt_d, s1_yt_d;
  logic [17:0]        s1_xl_q, s1_yl_q;
  logic signed [20:0] s1_xt_q, s1_yt_q;
  logic               s1_odd_q;
  logic [PixW-1:0]    s1_val_q;

  always_comb begin
    col_c = (int'(col_i) > int'(MAX_WIDTH) - 1) ? ColLim : col_i;
    row_c = (int'(row_i) > int'(MAX_HEIGHT) - 1) ? RowLim : row_i;
    s1_xl_d = {col_c, {FracW{1'b0}}};
    s1_yl_d = {row_c, {FracW{1'b0}}};
    s1_xt_d = $signed({3'b000, s1_xl_d}) - $signed({1'b0, cfg.lens_center_x});
    s1_yt_d = $signed({3'b000, s1_yl_d}) - $signed({1'b0, cfg.lens_center_y});
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      s1_xl_q  <= s1_xl_d;
      s1_yl_q  <= s1_yl_d;
      s1_xt_q  <= s1_xt_d;
      s1_yt_q  <= s1_yt_d;
      s1_odd_q <= row_c[0];
      s1_val_q <= pixel_value_i;
    end
  end

  // Stage 2: squares
  logic signed [41:0] sqx_full, sqy_full;
  logic [39:0]        s2_sqx_q, s2_sqy_q;
  logic [17:0]        s2_xl_q, s2_yl_q;
  logic signed [20:0] s2_xt_q, s2_yt_q;
  logic               s2_odd_q;
  logic [PixW-1:0]    s2_val_q;

  assign sqx_full = s1_xt_q * s1_xt_q;
  assign sqy_full = s1_yt_q * s1_yt_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[2]) begin
      s2_sqx_q <= sqx_full[39:0];
      s2_sqy_q <= sqy_full[39:0];
      s2_xl_q  <= s1_xl_q;
      s2_yl_q  <= s1_yl_q;
      s2_xt_q  <= s1_xt_q;
      s2_yt_q  <= s1_yt_q;
      s2_odd_q <= s1_odd_q;
      s2_val_q <= s1_val_q;
    end
  end

  // Stage 3: squared radius
  logic [40:0]        s3_r2_q;
  logic [17:0]        s3_xl_q, s3_yl_q;
  logic signed [20:0] s3_xt_q, s3_yt_q;
  logic               s3_odd_q;
  logic [PixW-1:0]    s3_val_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[3]) begin
      s3_r2_q  <= {1'b0, s2_sqx_q} + {1'b0, s2_sqy_q};
      s3_xl_q  <= s2_xl_q;
      s3_yl_q  <= s2_yl_q;
      s3_xt_q  <= s2_xt_q;
      s3_yt_q  <= s2_yt_q;
      s3_odd_q <= s2_odd_q;
      s3_val_q <= s2_val_q;
    end
  end

  // Stage 4: kappa * r2 as two partial products
  logic [36:0]        s4_plo_d, s4_plo_q;
  logic [35:0]        s4_phi_d, s4_phi_q;
  logic [17:0]        s4_xl_q, s4_yl_q;
  logic signed [20:0] s4_xt_q, s4_yt_q;
  logic               s4_odd_q;
  logic [PixW-1:0]    s4_val_q;

  assign s4_plo_d = cfg.kappa * s3_r2_q[20:0];
  assign s4_phi_d = cfg.kappa * s3_r2_q[40:21];

  always_ff @(posedge clk_i) begin
    if (stage_en[4]) begin
      s4_plo_q <= s4_plo_d;
      s4_phi_q <= s4_phi_d;
      s4_xl_q  <= s3_xl_q;
      s4_yl_q  <= s3_yl_q;
      s4_xt_q  <= s3_xt_q;
      s4_yt_q  <= s3_yt_q;
      s4_odd_q <= s3_odd_q;
      s4_val_q <= s3_val_q;
    end
  end

  // Stage 5: combine and round the correction fraction
  logic [57:0]        corr_sum;
  logic [33:0]        s5_corr_q;
  logic [17:0]        s5_xl_q, s5_yl_q;
  logic signed [20:0] s5_xt_q, s5_yt_q;
  logic               s5_odd_q;
  logic [PixW-1:0]    s5_val_q;

  assign corr_sum = {1'b0, s4_phi_q, 21'd0} + {21'd0, s4_plo_q} + CorrHalf;

  always_ff @(posedge clk_i) begin
    if (stage_en[5]) begin
      s5_corr_q <= corr_sum[57:24];
      s5_xl_q   <= s4_xl_q;
      s5_yl_q   <= s4_yl_q;
      s5_xt_q   <= s4_xt_q;
      s5_yt_q   <= s4_yt_q;
      s5_odd_q  <= s4_odd_q;
      s5_val_q  <= s4_val_q;
    end
  end

  // Stage 6: offset * correction, split over the correction's halves
  logic signed [38:0] s6_xmlo_d, s6_xmhi_d, s6_ymlo_d, s6_ymhi_d;
  logic signed [38:0] s6_xmlo_q, s6_xmhi_q, s6_ymlo_q, s6_ymhi_q;
  logic [17:0]        s6_xl_q, s6_yl_q;
  logic signed [20:0] s6_xt_q, s6_yt_q;
  logic               s6_odd_q;
  logic [PixW-1:0]    s6_val_q;

  assign s6_xmlo_d = s5_xt_q * $signed({1'b0, s5_corr_q[16:0]});
  assign s6_xmhi_d = s5_xt_q * $signed({1'b0, s5_corr_q[33:17]});
  assign s6_ymlo_d = s5_yt_q * $signed({1'b0, s5_corr_q[16:0]});
  assign s6_ymhi_d = s5_yt_q * $signed({1'b0, s5_corr_q[33:17]});

  always_ff @(posedge clk_i) begin
    if (stage_en[6]) begin
      s6_xmlo_q <= s6_xmlo_d;
      s6_xmhi_q <= s6_xmhi_d;
      s6_ymlo_q <= s6_ymlo_d;
      s6_ymhi_q <= s6_ymhi_d;
      s6_xl_q   <= s5_xl_q;
      s6_yl_q   <= s5_yl_q;
      s6_xt_q   <= s5_xt_q;
      s6_yt_q   <= s5_yt_q;
      s6_odd_q  <= s5_odd_q;
      s6_val_q  <= s5_val_q;
    end
  end

  // Stage 7: sum partial products, round by 2^32 (ties away from zero)
  logic signed [55:0] prod_x, prod_y, rnd_x, rnd_y;
  logic signed [23:0] s7_dlx_q, s7_dly_q;
  logic [17:0]        s7_xl_q, s7_yl_q;
  logic signed [20:0] s7_xt_q, s7_yt_q;
  logic               s7_odd_q;
  logic [PixW-1:0]    s7_val_q;

  always_comb begin
    prod_x = (56'(s6_xmhi_q) <<< 17) + 56'(s6_xmlo_q);
    prod_y = (56'(s6_ymhi_q) <<< 17) + 56'(s6_ymlo_q);
    // a negative value takes one off so the floor shift rounds ties outward
    rnd_x  = prod_x + LensHalf - 56'(prod_x[55]);
    rnd_y  = prod_y + LensHalf - 56'(prod_y[55]);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[7]) begin
      s7_dlx_q <= rnd_x[55:32];
      s7_dly_q <= rnd_y[55:32];
      s7_xl_q  <= s6_xl_q;
      s7_yl_q  <= s6_yl_q;
      s7_xt_q  <= s6_xt_q;
      s7_yt_q  <= s6_yt_q;
      s7_odd_q <= s6_odd_q;
      s7_val_q <= s6_val_q;
    end
  end

  // Stage 8: corrected position, or the plain one when the lens is off
  logic signed [24:0] s8_xn_d, s8_yn_d, s8_xn_q, s8_yn_q;
  logic               s8_odd_q;
  logic [PixW-1:0]    s8_val_q;

  always_comb begin
    if (cfg.lens_enable) begin
      s8_xn_d = 25'(s7_xt_q) + 25'(s7_dlx_q) + 25'($signed({1'b0, cfg.lens_center_x}));
      s8_yn_d = 25'(s7_yt_q) + 25'(s7_dly_q) + 25'($signed({1'b0, cfg.lens_center_y}));
    end else begin
      s8_xn_d = $signed({7'd0, s7_xl_q});
      s8_yn_d = $signed({7'd0, s7_yl_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[8]) begin
      s8_xn_q  <= s8_xn_d;
      s8_yn_q  <= s8_yn_d;
      s8_odd_q <= s7_odd_q;
      s8_val_q <= s7_val_q;
    end
  end

  // Stage 9: offsets from rotation centre, signed half-angle sine
  logic signed [25:0] s9_dx_q, s9_dy_q;
  logic signed [18:0] s9_s_d, s9_s_q;
  logic [PixW-1:0]    s9_val_q;

  assign s9_s_d = s8_odd_q ? 19'(cfg.sin_half_angle) : -19'(cfg.sin_half_angle);

  always_ff @(posedge clk_i) begin
    if (stage_en[9]) begin
      s9_dx_q  <= 26'(s8_xn_q) - 26'(cfg.rot_center_x);
      s9_dy_q  <= 26'(s8_yn_q) - 26'(cfg.rot_center_y);
      s9_s_q   <= s9_s_d;
      s9_val_q <= s8_val_q;
    end
  end

  // Stage 10: rotation products
  logic signed [44:0] s10_mxc_d, s10_mys_d, s10_mxs_d, s10_myc_d;
  logic signed [44:0] s10_mxc_q, s10_mys_q, s10_mxs_q, s10_myc_q;
  logic [PixW-1:0]    s10_val_q;

  assign s10_mxc_d = s9_dx_q * cfg.cos_half_angle;
  assign s10_mys_d = s9_dy_q * s9_s_q;
  assign s10_mxs_d = s9_dx_q * s9_s_q;
  assign s10_myc_d = s9_dy_q * cfg.cos_half_angle;

  always_ff @(posedge clk_i) begin
    if (stage_en[10]) begin
      s10_mxc_q <= s10_mxc_d;
      s10_mys_q <= s10_mys_d;
      s10_mxs_q <= s10_mxs_d;
      s10_myc_q <= s10_myc_d;
      s10_val_q <= s9_val_q;
    end
  end

  // Stage 11: combine and round Q.24 back to Q.8
  logic signed [45:0] sum_x, sum_y, rsum_x, rsum_y;
  logic signed [29:0] s11_xr_q, s11_yr_q;
  logic [PixW-1:0]    s11_val_q;

  always_comb begin
    sum_x  = 46'(s10_mxc_q) - 46'(s10_mys_q);
    sum_y  = 46'(s10_mxs_q) + 46'(s10_myc_q);
    rsum_x = sum_x + RotHalf - 46'(sum_x[45]);
    rsum_y = sum_y + RotHalf - 46'(sum_y[45]);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[11]) begin
      s11_xr_q  <= rsum_x[45:16];
      s11_yr_q  <= rsum_y[45:16];
      s11_val_q <= s10_val_q;
    end
  end

  // Stage 12: add the centre back, saturate; output register
  function automatic logic signed [CoordW-1:0] sat_q8(input logic signed [30:0] v);
    logic signed [CoordW-1:0] r;
    if (v > 31'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -31'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

  logic signed [30:0]       xo_full, yo_full;
  logic signed [CoordW-1:0] s12_x_q, s12_y_q;
  logic [PixW-1:0]          s12_val_q;

  assign xo_full = 31'(s11_xr_q) + 31'(cfg.rot_center_x);
  assign yo_full = 31'(s11_yr_q) + 31'(cfg.rot_center_y);

  always_ff @(posedge clk_i) begin
    if (stage_en[12]) begin
      s12_x_q   <= sat_q8(xo_full);
      s12_y_q   <= sat_q8(yo_full);
      s12_val_q <= s11_val_q;
    end
  end

  assign x_out_o     = s12_x_q;
  assign y_out_o     = s12_y_q;
  assign value_out_o = s12_val_q;

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[1])
    else $error("accepted transfer did not enter the first stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q))
    else $error("input held off while the pipeline has an empty stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ready_i && v_q[NS-1]) |=> v_q[NS])
    else $error("pixel failed to advance into the output register");

endmodule

/* rtl/prlc_cfg_regs.sv */
`timescale 1ns / 1ps

module prlc_cfg_regs import prlc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ApbAW-1:0] paddr,
  input  logic [ApbDW-1:0] pwdata,
  output logic [ApbDW-1:0] prdata,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_e'(paddr[ApbAW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_half_angle <= CosReset;
      cfg_q.sin_half_angle <= SinReset;
      cfg_q.rot_center_x   <= RotCxReset;
      cfg_q.rot_center_y   <= RotCyReset;
      cfg_q.lens_enable    <= LensEnReset;
      cfg_q.lens_center_x  <= LensCxReset;
      cfg_q.lens_center_y  <= LensCyReset;
      cfg_q.kappa          <= KappaReset;
    end else if (wr_en) begin
      case (idx)
        REG_COS:     cfg_q.cos_half_angle <= pwdata[TrigW-1:0];
        REG_SIN:     cfg_q.sin_half_angle <= pwdata[TrigW-1:0];
        REG_ROT_CX:  cfg_q.rot_center_x   <= pwdata[CoordW-1:0];
        REG_ROT_CY:  cfg_q.rot_center_y   <= pwdata[CoordW-1:0];
        REG_LENS_EN: cfg_q.lens_enable    <= pwdata[0];
        REG_LENS_CX: cfg_q.lens_center_x  <= pwdata[LensCW-1:0];
        REG_LENS_CY: cfg_q.lens_center_y  <= pwdata[LensCW-1:0];
        REG_KAPPA:   cfg_q.kappa          <= pwdata[KappaW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_COS:     prdata[TrigW-1:0]  = cfg_q.cos_half_angle;
      REG_SIN:     prdata[TrigW-1:0]  = cfg_q.sin_half_angle;
      REG_ROT_CX:  prdata[CoordW-1:0] = cfg_q.rot_center_x;
      REG_ROT_CY:  prdata[CoordW-1:0] = cfg_q.rot_center_y;
      REG_LENS_EN: prdata[0]          = cfg_q.lens_enable;
      REG_LENS_CX: prdata[LensCW-1:0] = cfg_q.lens_center_x;
      REG_LENS_CY: prdata[LensCW-1:0] = cfg_q.lens_center_y;
      REG_KAPPA:   prdata[KappaW-1:0] = cfg_q.kappa;
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* tb/sv/pixel_rotate_lens_correct_unit_tb.sv */
`timescale 1ns / 1ps

module pixel_rotate_lens_correct_unit_tb;
  import prlc_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned Latency     = 12;
  localparam int unsigned RandomItems = 1750;
  localparam longint      CoordMax    = 64'sd8388607;
  localparam longint      CoordMin    = -64'sd8388608;

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [PixW-1:0]          value;
  } coord_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_ready_o;
  logic [ColW-1:0]          col_i         = '0;
  logic [RowW-1:0]          row_i         = '0;
  logic [PixW-1:0]          pixel_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i   = 1'b0;
  logic signed [CoordW-1:0] x_out_o;
  logic signed [CoordW-1:0] y_out_o;
  logic [PixW-1:0]          value_out_o;
  logic                     psel          = 1'b0;
  logic                     penable       = 1'b0;
  logic                     pwrite        = 1'b0;
  logic [ApbAW-1:0]         paddr         = '0;
  logic [ApbDW-1:0]         pwdata        = '0;
  logic [ApbDW-1:0]         prdata;
  logic                     pready;

  cfg_t        shadow_cfg;
  coord_t      expected_coords[$];
  int          mismatch_count = 0;
  int          burst_left     = 0;
  int unsigned cycle_count    = 0;
  int          stall_mode     = 0;
  int          stall_left     = 0;

  pixel_rotate_lens_correct_unit DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Predictor: round to nearest with ties away from zero
  function automatic longint round_shift(longint v, int unsigned sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  function automatic longint saturate(longint v);
    if (v > CoordMax) return CoordMax;
    if (v < CoordMin) return CoordMin;
    return v;
  endfunction

  function automatic coord_t predict_coord(logic [ColW-1:0] c, logic [RowW-1:0] r,
                                           logic [PixW-1:0] v);
    longint cx, ry, px, py, xt, yt, corr, cs, sn, rcx, rcy, dx, dy, xo, yo;
    coord_t res;
    cx = longint'(c);
    ry = longint'(r);
    if (cx > longint'(MaxWidthDef) - 1) cx = longint'(MaxWidthDef) - 1;
    if (ry > longint'(MaxHeightDef) - 1) ry = longint'(MaxHeightDef) - 1;
    px = cx * 256;
    py = ry * 256;
    if (shadow_cfg.lens_enable) begin
      xt = px - longint'(shadow_cfg.lens_center_x);
      yt = py - longint'(shadow_cfg.lens_center_y);
      corr = (longint'(shadow_cfg.kappa) * (xt * xt + yt * yt) + (longint'(1) << 23)) >>> 24;
      px = xt + round_shift(xt * corr, 32) + longint'(shadow_cfg.lens_center_x);
      py = yt + round_shift(yt * corr, 32) + longint'(shadow_cfg.lens_center_y);
    end
    cs  = longint'($signed(shadow_cfg.cos_half_angle));
    sn  = longint'($signed(shadow_cfg.sin_half_angle));
    rcx = longint'($signed(shadow_cfg.rot_center_x));
    rcy = longint'($signed(shadow_cfg.rot_center_y));
    // even rows turn the other way
    if (ry[0] == 1'b0) sn = -sn;
    dx = px - rcx;
    dy = py - rcy;
    xo = saturate(round_shift(dx * cs - dy * sn, 16) + rcx);
    yo = saturate(round_shift(dx * sn + dy * cs, 16) + rcy);
    res.x     = CoordW'(xo);
    res.y     = CoordW'(yo);
    res.value = v;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Receiver: stall in phases of random length and style
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 3) ? $urandom_range(2, 16) : $urandom_range(8, 120);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: out_ready_i <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    coord_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_coords.size() == 0) begin
        report_mismatch("result with none outstanding, x_out", x_out_o, 0);
      end else begin
        want = expected_coords.pop_front();
        if (x_out_o !== want.x) report_mismatch("x_out", x_out_o, want.x);
        if (y_out_o !== want.y) report_mismatch("y_out", y_out_o, want.y);
        if (value_out_o !== want.value) report_mismatch("value_out", value_out_o, want.value);
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, int value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_COS:     shadow_cfg.cos_half_angle = value[TrigW-1:0];
      REG_SIN:     shadow_cfg.sin_half_angle = value[TrigW-1:0];
      REG_ROT_CX:  shadow_cfg.rot_center_x   = value[CoordW-1:0];
      REG_ROT_CY:  shadow_cfg.rot_center_y   = value[CoordW-1:0];
      REG_LENS_EN: shadow_cfg.lens_enable    = value[0];
      REG_LENS_CX: shadow_cfg.lens_center_x  = value[LensCW-1:0];
      REG_LENS_CY: shadow_cfg.lens_center_y  = value[LensCW-1:0];
      REG_KAPPA:   shadow_cfg.kappa          = value[KappaW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid and hold until every outstanding result has been checked
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_coords.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [ColW-1:0] c, logic [RowW-1:0] r, logic [PixW-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    col_i         <= c;
    row_i         <= r;
    pixel_value_i <= v;
    burst_left--;
    do @(posedge clk_i); while (!in_ready_o);
    expected_coords.push_back(predict_coord(c, r, v));
  endtask

  function automatic int pick_value(int lo, int hi);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  task automatic test_identity_passthrough();
    send_pixel(0, 0, 8'd0);
    send_pixel(1023, 1023, 8'd255);
    send_pixel(1023, 0, 8'd170);
    send_pixel(0, 1023, 8'd85);
    send_pixel(512, 513, 8'd1);
  endtask

  task automatic test_default_lens();
    wait_idle();
    write_reg(REG_LENS_EN, 1);
    send_pixel(0, 0, 8'd17);
    send_pixel(1023, 1023, 8'd34);
    // pixel on the lens centre stays put
    send_pixel(383, 257, 8'd51);
    send_pixel(1023, 0, 8'd68);
  endtask

  task automatic test_lens_extremes();
    wait_idle();
    write_reg(REG_KAPPA, 65535);
    write_reg(REG_LENS_CX, 1048575);
    write_reg(REG_LENS_CY, 1048575);
    send_pixel(0, 0, 8'd200);
    send_pixel(1023, 1023, 8'd201);
    wait_idle();
    write_reg(REG_LENS_CX, 0);
    write_reg(REG_LENS_CY, 0);
    send_pixel(1023, 1023, 8'd202);
    send_pixel(1023, 1022, 8'd203);
  endtask

  // Trig values beyond one and centres at the ends of the range drive saturation
  task automatic test_trig_extremes();
    wait_idle();
    write_reg(REG_LENS_EN, 0);
    write_reg(REG_COS, 131071);
    write_reg(REG_SIN, -131072);
    write_reg(REG_ROT_CX, -8388608);
    write_reg(REG_ROT_CY, 8388607);
    send_pixel(0, 1, 8'd10);
    send_pixel(1023, 0, 8'd20);
    wait_idle();
    write_reg(REG_COS, -131072);
    write_reg(REG_SIN, 131071);
    write_reg(REG_ROT_CX, 8388607);
    write_reg(REG_ROT_CY, -8388608);
    send_pixel(1023, 1023, 8'd30);
    send_pixel(0, 0, 8'd40);
    wait_idle();
    write_reg(REG_COS, -65536);
    write_reg(REG_SIN, 65536);
    write_reg(REG_ROT_CX, 0);
    write_reg(REG_ROT_CY, 0);
    send_pixel(100, 201, 8'd50);
    send_pixel(100, 200, 8'd60);
  endtask

  task automatic randomise_config();
    write_reg(REG_COS, ($urandom_range(0, 7) == 0) ? pick_value(-131072, 131071)
                                                    : pick_value(-65536, 65536));
    write_reg(REG_SIN, ($urandom_range(0, 7) == 0) ? pick_value(-131072, 131071)
                                                    : pick_value(-65536, 65536));
    write_reg(REG_ROT_CX, ($urandom_range(0, 3) == 0) ? pick_value(-8388608, 8388607)
                                                       : pick_value(0, 262143));
    write_reg(REG_ROT_CY, ($urandom_range(0, 3) == 0) ? pick_value(-8388608, 8388607)
                                                       : pick_value(0, 262143));
    write_reg(REG_LENS_EN, int'($urandom_range(0, 2) != 0));
    write_reg(REG_LENS_CX, ($urandom_range(0, 3) == 0) ? pick_value(0, 1048575)
                                                        : pick_value(0, 262143));
    write_reg(REG_LENS_CY, ($urandom_range(0, 3) == 0) ? pick_value(0, 1048575)
                                                        : pick_value(0, 262143));
    write_reg(REG_KAPPA, pick_value(0, 65535));
  endtask

  task automatic test_random_phases();
    int sent;
    int phase_len;
    sent = 0;
    while (sent < RandomItems) begin
      wait_idle();
      randomise_config();
      phase_len = $urandom_range(40, 220);
      repeat (phase_len) begin
        send_pixel(ColW'($urandom_range(0, 1023)), RowW'($urandom_range(0, 1023)),
                   PixW'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    shadow_cfg = '{cos_half_angle: CosReset, sin_half_angle: SinReset,
                   rot_center_x: RotCxReset, rot_center_y: RotCyReset,
                   lens_enable: LensEnReset, lens_center_x: LensCxReset,
                   lens_center_y: LensCyReset, kappa: KappaReset};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_identity_passthrough();
    test_default_lens();
    test_lens_extremes();
    test_trig_extremes();
    test_random_phases();
    wait_idle();
    repeat (Latency + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
